// File: src/vucrp_pkg.sv
// ----------------------------------------------------------------------------
// vucrp_pkg
// Shared codes, types and helpers of the video unit CPU register port.
// ----------------------------------------------------------------------------
package vucrp_pkg;

   localparam int SPRITE_BYTES    = 256;
   localparam int PALETTE_ENTRIES = 32;
   localparam int SPR_AW          = $clog2(SPRITE_BYTES);
   localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);

   // request codes
   localparam logic [2:0] REQ_READ      = 3'd0;
   localparam logic [2:0] REQ_WRITE     = 3'd1;
   localparam logic [2:0] REQ_VBLANK    = 3'd2;
   localparam logic [2:0] REQ_PRERENDER = 3'd3;
   localparam logic [2:0] REQ_SPR_ZERO  = 3'd4;
   localparam logic [2:0] REQ_OVERFLOW  = 3'd5;

   // register indexes
   localparam logic [2:0] REG_CTRL     = 3'd0;
   localparam logic [2:0] REG_MASK     = 3'd1;
   localparam logic [2:0] REG_STATUS   = 3'd2;
   localparam logic [2:0] REG_OAM_ADDR = 3'd3;
   localparam logic [2:0] REG_OAM_DATA = 3'd4;
   localparam logic [2:0] REG_SCROLL   = 3'd5;
   localparam logic [2:0] REG_ADDR     = 3'd6;
   localparam logic [2:0] REG_DATA     = 3'd7;

   localparam logic [13:0] PAL_BASE_LAST = 14'h3eff;

   typedef struct packed {
      logic              rd_en;
      logic              spr_we;
      logic [SPR_AW-1:0] spr_addr;
      logic              pal_we;
      logic [PAL_AW-1:0] pal_addr;
      logic [7:0]        wdata;
   } store_req_type;

   typedef struct packed {
      logic [7:0] spr_data;
      logic [7:0] pal_data;
   } store_rsp_type;

   // backdrop mirroring: 0x10/0x14/0x18/0x1c alias 0x00/0x04/0x08/0x0c
   function automatic logic [PAL_AW-1:0] pal_index(input logic [13:0] addr);
      logic [PAL_AW-1:0] idx;
      idx = addr[PAL_AW-1:0];
      if (idx[4] && (idx[1:0] == 2'b00)) begin
         idx[4] = 1'b0;
      end
      return idx;
   endfunction

endpackage

// File: src/vucrp_store.sv
// ----------------------------------------------------------------------------
// vucrp_store
// Sprite and palette memories, registered read, per-entry valid
// bits so that unwritten entries read as zero after reset.
// ----------------------------------------------------------------------------
module vucrp_store (
   input  logic                    clock,
   input  logic                    reset,
   input  vucrp_pkg::store_req_type req,
   output vucrp_pkg::store_rsp_type rsp
);

   logic [7:0] spr_ram [vucrp_pkg::SPRITE_BYTES];
   logic [7:0] pal_ram [vucrp_pkg::PALETTE_ENTRIES];

   logic [vucrp_pkg::SPRITE_BYTES-1:0]    spr_vld_ff;
   logic [vucrp_pkg::PALETTE_ENTRIES-1:0] pal_vld_ff;
   logic [7:0]                            spr_q_ff;
   logic [7:0]                            pal_q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         spr_vld_ff <= '0;
         pal_vld_ff <= '0;
      end else begin
         if (req.spr_we) begin
            spr_vld_ff[req.spr_addr] <= 1'b1;
         end
         if (req.pal_we) begin
            pal_vld_ff[req.pal_addr] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.spr_we) begin
         spr_ram[req.spr_addr] <= req.wdata;
      end
      if (req.pal_we) begin
         pal_ram[req.pal_addr] <= req.wdata;
      end
      if (req.rd_en) begin
         spr_q_ff <= spr_vld_ff[req.spr_addr] ? spr_ram[req.spr_addr] : 8'h00;
         pal_q_ff <= pal_vld_ff[req.pal_addr] ? pal_ram[req.pal_addr] : 8'h00;
      end
   end

   assign rsp.spr_data = spr_q_ff;
   assign rsp.pal_data = pal_q_ff;

endmodule

// File: src/video_unit_cpu_register_port.sv
// Results are registered: an item accepted at a clock edge is shown after that edge.
// Throughput: 1 item per cycle; the output register frees while rsp_ready.
// Sprite and palette reads use the registered read port of vucrp_store.
// Reset: synchronous, clears the port registers and memory valid bits at once;
// no clearing pass, items are taken in the first cycle after reset.
// ----------------------------------------------------------------------------
// video_unit_cpu_register_port
// CPU register port of a tile video unit: scroll/address registers, buffered
// VRAM reads, palette and sprite memory, status flags and NMI level.
// ----------------------------------------------------------------------------
module video_unit_cpu_register_port (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [2:0]  req_type,
   input  logic [2:0]  req_reg_index,
   input  logic [7:0]  req_wdata,
   input  logic        req_rendering_active,
   input  logic [7:0]  req_ext_rdata,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_rdata,
   output logic        rsp_nmi_level,
   output logic [13:0] rsp_mem_addr,
   output logic        rsp_mem_read,
   output logic        rsp_mem_write,
   output logic [7:0]  rsp_mem_wdata,
   output logic [14:0] rsp_vram_addr,
   output logic [14:0] rsp_temp_addr,
   output logic [2:0]  rsp_fine_scroll_x,
   output logic [7:0]  rsp_ctrl_bits,
   output logic [7:0]  rsp_mask_bits
);

   typedef enum logic [2:0] {
      RD_ZERO,
      RD_DIRECT,
      RD_SPRITE,
      RD_SPRITE_ATTR,
      RD_PALETTE,
      RD_PALETTE_GRAY
   } rd_sel_type;

   logic [14:0] cur_ff, cur_in;
   logic [14:0] tmp_ff, tmp_in;
   logic [2:0]  fine_x_ff, fine_x_in;
   logic        toggle_ff, toggle_in;
   logic [7:0]  rbuf_ff, rbuf_in;
   logic [7:0]  last_ff, last_in;
   logic [7:0]  ctrl_ff, ctrl_in;
   logic [7:0]  mask_ff, mask_in;
   logic [2:0]  status_ff, status_in;
   logic [7:0]  spr_ptr_ff, spr_ptr_in;

   logic        valid_ff;
   rd_sel_type  rd_sel_ff, rd_sel_in;
   logic [7:0]  rd_direct_ff, rd_direct_in;
   logic [13:0] maddr_ff, maddr_in;
   logic        mrd_ff, mrd_in;
   logic        mwr_ff, mwr_in;
   logic [7:0]  mwd_ff, mwd_in;

   logic        accept;
   logic [13:0] vaddr;
   logic        is_pal;
   logic [14:0] vram_step;
   logic        data_open;

   vucrp_pkg::store_req_type st_req;
   vucrp_pkg::store_rsp_type st_rsp;

   assign req_ready = !reset && (!valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign vaddr     = cur_ff[13:0];
   assign is_pal    = vaddr > vucrp_pkg::PAL_BASE_LAST;
   assign vram_step = ctrl_ff[2] ? 15'd32 : 15'd1;
   assign data_open = (req_reg_index == vucrp_pkg::REG_DATA) && !req_rendering_active;

   always_comb begin
      cur_in       = cur_ff;
      tmp_in       = tmp_ff;
      fine_x_in    = fine_x_ff;
      toggle_in    = toggle_ff;
      rbuf_in      = rbuf_ff;
      last_in      = last_ff;
      ctrl_in      = ctrl_ff;
      mask_in      = mask_ff;
      status_in    = status_ff;
      spr_ptr_in   = spr_ptr_ff;
      rd_sel_in    = RD_ZERO;
      rd_direct_in = 8'h00;
      maddr_in     = 14'h0000;
      mrd_in       = 1'b0;
      mwr_in       = 1'b0;
      mwd_in       = 8'h00;

      st_req.rd_en    = accept;
      st_req.spr_we   = 1'b0;
      st_req.spr_addr = spr_ptr_ff;
      st_req.pal_we   = 1'b0;
      st_req.pal_addr = vucrp_pkg::pal_index(vaddr);
      st_req.wdata    = req_wdata;

      unique case (req_type)
         vucrp_pkg::REQ_READ: begin
            unique case (req_reg_index)
               vucrp_pkg::REG_STATUS: begin
                  rd_sel_in    = RD_DIRECT;
                  rd_direct_in = {status_ff, last_ff[4:0]};
                  status_in    = {1'b0, status_ff[1:0]};
                  toggle_in    = 1'b0;
               end
               vucrp_pkg::REG_OAM_DATA: begin
                  rd_sel_in = (spr_ptr_ff[1:0] == 2'd2) ? RD_SPRITE_ATTR : RD_SPRITE;
               end
               vucrp_pkg::REG_DATA: begin
                  if (data_open) begin
                     if (is_pal) begin
                        rd_sel_in = mask_ff[0] ? RD_PALETTE_GRAY : RD_PALETTE;
                     end else begin
                        rd_sel_in    = RD_DIRECT;
                        rd_direct_in = rbuf_ff;
                     end
                     rbuf_in  = req_ext_rdata;
                     maddr_in = vaddr;
                     mrd_in   = 1'b1;
                     cur_in   = cur_ff + vram_step;
                  end
               end
               default: begin
               end
            endcase
         end
         vucrp_pkg::REQ_WRITE: begin
            last_in = req_wdata;
            unique case (req_reg_index)
               vucrp_pkg::REG_CTRL: begin
                  ctrl_in = req_wdata;
                  tmp_in  = {tmp_ff[14:12], req_wdata[1:0], tmp_ff[9:0]};
               end
               vucrp_pkg::REG_MASK: begin
                  mask_in = req_wdata;
               end
               vucrp_pkg::REG_OAM_ADDR: begin
                  spr_ptr_in = req_wdata;
               end
               vucrp_pkg::REG_OAM_DATA: begin
                  st_req.spr_we = accept;
                  spr_ptr_in    = spr_ptr_ff + 8'd1;
               end
               vucrp_pkg::REG_SCROLL: begin
                  if (!toggle_ff) begin
                     fine_x_in = req_wdata[2:0];
                     tmp_in    = {tmp_ff[14:5], req_wdata[7:3]};
                  end else begin
                     tmp_in = {req_wdata[2:0], tmp_ff[11:10], req_wdata[7:3], tmp_ff[4:0]};
                  end
                  toggle_in = !toggle_ff;
               end
               vucrp_pkg::REG_ADDR: begin
                  if (!toggle_ff) begin
                     tmp_in = {1'b0, req_wdata[5:0], tmp_ff[7:0]};
                  end else begin
                     tmp_in = {tmp_ff[14:8], req_wdata};
                     cur_in = {tmp_ff[14:8], req_wdata};
                  end
                  toggle_in = !toggle_ff;
               end
               vucrp_pkg::REG_DATA: begin
                  if (data_open) begin
                     maddr_in = vaddr;
                     if (is_pal) begin
                        st_req.pal_we = accept;
                     end else begin
                        mwr_in = 1'b1;
                        mwd_in = req_wdata;
                     end
                     cur_in = cur_ff + vram_step;
                  end
               end
               default: begin
               end
            endcase
         end
         vucrp_pkg::REQ_VBLANK:    status_in = status_ff | 3'b100;
         vucrp_pkg::REQ_PRERENDER: status_in = 3'b000;
         vucrp_pkg::REQ_SPR_ZERO:  status_in = status_ff | 3'b010;
         vucrp_pkg::REQ_OVERFLOW:  status_in = status_ff | 3'b001;
         default: begin
         end
      endcase
   end

   vucrp_store u_store (
      .clock (clock),
      .reset (reset),
      .req   (st_req),
      .rsp   (st_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= 1'b0;
         cur_ff       <= '0;
         tmp_ff       <= '0;
         fine_x_ff    <= '0;
         toggle_ff    <= 1'b0;
         rbuf_ff      <= '0;
         last_ff      <= '0;
         ctrl_ff      <= '0;
         mask_ff      <= '0;
         status_ff    <= '0;
         spr_ptr_ff   <= '0;
         rd_sel_ff    <= RD_ZERO;
         rd_direct_ff <= '0;
         maddr_ff     <= '0;
         mrd_ff       <= 1'b0;
         mwr_ff       <= 1'b0;
         mwd_ff       <= '0;
      end else begin
         if (accept) begin
            valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            valid_ff <= 1'b0;
         end
         if (accept) begin
            cur_ff       <= cur_in;
            tmp_ff       <= tmp_in;
            fine_x_ff    <= fine_x_in;
            toggle_ff    <= toggle_in;
            rbuf_ff      <= rbuf_in;
            last_ff      <= last_in;
            ctrl_ff      <= ctrl_in;
            mask_ff      <= mask_in;
            status_ff    <= status_in;
            spr_ptr_ff   <= spr_ptr_in;
            rd_sel_ff    <= rd_sel_in;
            rd_direct_ff <= rd_direct_in;
            maddr_ff     <= maddr_in;
            mrd_ff       <= mrd_in;
            mwr_ff       <= mwr_in;
            mwd_ff       <= mwd_in;
         end
      end
   end

   always_comb begin
      unique case (rd_sel_ff)
         RD_DIRECT:       rsp_rdata = rd_direct_ff;
         RD_SPRITE:       rsp_rdata = st_rsp.spr_data;
         RD_SPRITE_ATTR:  rsp_rdata = st_rsp.spr_data & 8'he3;
         RD_PALETTE:      rsp_rdata = st_rsp.pal_data;
         RD_PALETTE_GRAY: rsp_rdata = st_rsp.pal_data & 8'h30;
         default:         rsp_rdata = 8'h00;
      endcase
   end

   assign rsp_valid         = valid_ff;
   assign rsp_nmi_level     = ctrl_ff[7] && status_ff[2];
   assign rsp_mem_addr      = maddr_ff;
   assign rsp_mem_read      = mrd_ff;
   assign rsp_mem_write     = mwr_ff;
   assign rsp_mem_wdata     = mwd_ff;
   assign rsp_vram_addr     = cur_ff;
   assign rsp_temp_addr     = tmp_ff;
   assign rsp_fine_scroll_x = fine_x_ff;
   assign rsp_ctrl_bits     = ctrl_ff;
   assign rsp_mask_bits     = mask_ff;

endmodule

// File: src/vucrp_checker.sv
// ----------------------------------------------------------------------------
// vucrp_checker
// Port-level checks of the video unit CPU register port, bound to the top.
// ----------------------------------------------------------------------------
module vucrp_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic        rsp_nmi_level,
   input logic [13:0] rsp_mem_addr,
   input logic        rsp_mem_read,
   input logic        rsp_mem_write,
   input logic [7:0]  rsp_mem_wdata,
   input logic [7:0]  rsp_ctrl_bits
);

   a_rd_wr_excl: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_mem_read && rsp_mem_write))
      else $error("memory read and write in one item");

   a_wdata_idle: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_mem_write) |-> (rsp_mem_wdata == 8'h00))
      else $error("write data without memory write");

   a_wr_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_mem_write) |-> (rsp_mem_addr <= 14'h3eff))
      else $error("external write to palette range");

   a_nmi_ctrl: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_nmi_level) |-> rsp_ctrl_bits[7])
      else $error("nmi without enable");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result item dropped while stalled");

endmodule

bind video_unit_cpu_register_port vucrp_checker u_vucrp_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_nmi_level (rsp_nmi_level),
   .rsp_mem_addr  (rsp_mem_addr),
   .rsp_mem_read  (rsp_mem_read),
   .rsp_mem_write (rsp_mem_write),
   .rsp_mem_wdata (rsp_mem_wdata),
   .rsp_ctrl_bits (rsp_ctrl_bits)
);

// File: verif/video_unit_cpu_register_port_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// video_unit_cpu_register_port_test
// Self-checking bench for the CPU register port. A queue of bus accesses and
// timing events drives the request side with random gaps, the response side
// stalls at random and once for a long stretch. A cycle-free model of the
// port predicts every response, which is checked field by field in order.
// ----------------------------------------------------------------------------
module video_unit_cpu_register_port_test;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int RANDOM_ITEMS   = 600;
   localparam int LONG_HOLD      = 80;
   localparam int FLAG_VBLANK    = 2;
   localparam int FLAG_SPR_ZERO  = 1;
   localparam int FLAG_OVERFLOW  = 0;
   localparam logic [2:0] REQ_UNUSED_A = 3'd6;
   localparam logic [2:0] REQ_UNUSED_B = 3'd7;

   typedef struct packed {
      logic [2:0] kind;
      logic [2:0] reg_sel;
      logic [7:0] wdata;
      logic       rendering;
      logic [7:0] ext;
   } bus_item_type;

   typedef struct packed {
      logic [7:0]  rdata;
      logic        nmi_level;
      logic [13:0] mem_addr;
      logic        mem_read;
      logic        mem_write;
      logic [7:0]  mem_wdata;
      logic [14:0] vram_addr;
      logic [14:0] temp_addr;
      logic [2:0]  fine_scroll_x;
      logic [7:0]  ctrl_bits;
      logic [7:0]  mask_bits;
   } port_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [2:0]  req_type = '0;
   logic [2:0]  req_reg_index = '0;
   logic [7:0]  req_wdata = '0;
   logic        req_rendering_active = 1'b0;
   logic [7:0]  req_ext_rdata = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_rdata;
   logic        rsp_nmi_level;
   logic [13:0] rsp_mem_addr;
   logic        rsp_mem_read;
   logic        rsp_mem_write;
   logic [7:0]  rsp_mem_wdata;
   logic [14:0] rsp_vram_addr;
   logic [14:0] rsp_temp_addr;
   logic [2:0]  rsp_fine_scroll_x;
   logic [7:0]  rsp_ctrl_bits;
   logic [7:0]  rsp_mask_bits;

   video_unit_cpu_register_port u_top (.*);

   always #5 clock = ~clock;

   // model state
   logic [14:0] cur_addr = '0;
   logic [14:0] tmp_addr = '0;
   logic [2:0]  fine_x = '0;
   logic        toggle = 1'b0;
   logic [7:0]  read_buf = '0;
   logic [7:0]  last_wr = '0;
   logic [7:0]  ctrl_r = '0;
   logic [7:0]  mask_r = '0;
   logic [2:0]  flags = '0;
   logic [7:0]  oam_ptr = '0;
   logic [7:0]  oam [vucrp_pkg::SPRITE_BYTES] = '{default: 8'h00};
   logic [7:0]  palette [vucrp_pkg::PALETTE_ENTRIES] = '{default: 8'h00};

   bus_item_type    bus_items[$];
   port_result_type port_results_due[$];
   int items_total = 0;
   int items_accepted = 0;
   int results_seen = 0;
   int errors = 0;
   int idle_cycles = 0;
   int send_gap = 0;
   int ready_gap = 0;
   int long_hold_left = 0;
   bit long_hold_done = 0;
   bit req_taken = 0;

   function automatic logic [4:0] palette_slot(input logic [13:0] a);
      logic [4:0] s;
      s = a[4:0];
      if ((s & 5'h13) == 5'h10) s[4] = 1'b0;
      return s;
   endfunction

   task automatic apply_bus_event(input bus_item_type it, output port_result_type r);
      logic [13:0] a;
      logic [14:0] incr;
      logic [7:0]  d;
      r = '0;
      a = cur_addr[13:0];
      incr = ctrl_r[2] ? 15'd32 : 15'd1;
      d = it.wdata;
      case (it.kind)
         vucrp_pkg::REQ_READ: begin
            if (it.reg_sel == vucrp_pkg::REG_STATUS) begin
               r.rdata = {flags, last_wr[4:0]};
               flags[FLAG_VBLANK] = 1'b0;
               toggle = 1'b0;
            end else if (it.reg_sel == vucrp_pkg::REG_OAM_DATA) begin
               r.rdata = oam[oam_ptr];
               if (oam_ptr[1:0] == 2'd2) r.rdata = r.rdata & 8'he3;
            end else if (it.reg_sel == vucrp_pkg::REG_DATA && !it.rendering) begin
               if (a <= vucrp_pkg::PAL_BASE_LAST) begin
                  r.rdata = read_buf;
               end else begin
                  r.rdata = palette[palette_slot(a)];
                  if (mask_r[0]) r.rdata = r.rdata & 8'h30;
               end
               read_buf = it.ext;
               r.mem_addr = a;
               r.mem_read = 1'b1;
               cur_addr = cur_addr + incr;
            end
         end
         vucrp_pkg::REQ_WRITE: begin
            last_wr = d;
            case (it.reg_sel)
               vucrp_pkg::REG_CTRL: begin
                  ctrl_r = d;
                  tmp_addr[11:10] = d[1:0];
               end
               vucrp_pkg::REG_MASK: mask_r = d;
               vucrp_pkg::REG_OAM_ADDR: oam_ptr = d;
               vucrp_pkg::REG_OAM_DATA: begin
                  oam[oam_ptr] = d;
                  oam_ptr = oam_ptr + 8'd1;
               end
               vucrp_pkg::REG_SCROLL: begin
                  if (!toggle) begin
                     fine_x = d[2:0];
                     tmp_addr[4:0] = d[7:3];
                  end else begin
                     tmp_addr[14:12] = d[2:0];
                     tmp_addr[9:5] = d[7:3];
                  end
                  toggle = ~toggle;
               end
               vucrp_pkg::REG_ADDR: begin
                  if (!toggle) begin
                     tmp_addr[14:8] = {1'b0, d[5:0]};
                  end else begin
                     tmp_addr[7:0] = d;
                     cur_addr = tmp_addr;
                  end
                  toggle = ~toggle;
               end
               vucrp_pkg::REG_DATA: begin
                  if (!it.rendering) begin
                     r.mem_addr = a;
                     if (a <= vucrp_pkg::PAL_BASE_LAST) begin
                        r.mem_write = 1'b1;
                        r.mem_wdata = d;
                     end else begin
                        palette[palette_slot(a)] = d;
                     end
                     cur_addr = cur_addr + incr;
                  end
               end
               default: ;
            endcase
         end
         vucrp_pkg::REQ_VBLANK: flags[FLAG_VBLANK] = 1'b1;
         vucrp_pkg::REQ_PRERENDER: flags = '0;
         vucrp_pkg::REQ_SPR_ZERO: flags[FLAG_SPR_ZERO] = 1'b1;
         vucrp_pkg::REQ_OVERFLOW: flags[FLAG_OVERFLOW] = 1'b1;
         default: ;
      endcase
      r.nmi_level = ctrl_r[7] & flags[FLAG_VBLANK];
      r.vram_addr = cur_addr;
      r.temp_addr = tmp_addr;
      r.fine_scroll_x = fine_x;
      r.ctrl_bits = ctrl_r;
      r.mask_bits = mask_r;
   endtask

   task automatic queue_item(input logic [2:0] kind, input logic [2:0] reg_sel,
                             input logic [7:0] wdata, input logic rendering);
      bus_item_type it;
      it.kind = kind;
      it.reg_sel = reg_sel;
      it.wdata = wdata;
      it.rendering = rendering;
      it.ext = 8'($urandom);
      bus_items.push_back(it);
   endtask

   function automatic logic busy_line();
      return $urandom_range(0, 7) == 0;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s expected %h actual %h", $time, name, want, got);
      end
   endtask

   // request driver
   always @(negedge clock) begin
      bus_item_type it;
      if (!reset) begin
         if (req_valid && !req_taken) begin
         end else if (send_gap > 0) begin
            send_gap--;
            req_valid <= 1'b0;
         end else if (bus_items.size() >= 60 && long_hold_left == 0 &&
                      $urandom_range(0, 7) == 0) begin
            send_gap = $urandom_range(0, 12);
            req_valid <= 1'b0;
         end else if (bus_items.size() > 0) begin
            it = bus_items.pop_front();
            req_valid <= 1'b1;
            req_type <= it.kind;
            req_reg_index <= it.reg_sel;
            req_wdata <= it.wdata;
            req_rendering_active <= it.rendering;
            req_ext_rdata <= it.ext;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response side stalls
   always @(negedge clock) begin
      if (!reset) begin
         if (long_hold_left > 0) begin
            long_hold_left--;
            rsp_ready <= 1'b0;
         end else if (ready_gap > 0) begin
            ready_gap--;
            rsp_ready <= 1'b0;
         end else if (!long_hold_done && results_seen >= 200) begin
            long_hold_done = 1;
            long_hold_left = LONG_HOLD;
            rsp_ready <= 1'b0;
         end else if (bus_items.size() >= 60 && $urandom_range(0, 7) == 0) begin
            ready_gap = $urandom_range(0, 12);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // monitor, prediction and watchdog
   always @(posedge clock) begin : check_port
      bus_item_type    it;
      port_result_type due;
      port_result_type seen;
      bit rsp_taken;
      req_taken = !reset && req_valid && req_ready;
      rsp_taken = !reset && rsp_valid && rsp_ready;
      if (rsp_taken) begin
         results_seen++;
         seen = '{rsp_rdata, rsp_nmi_level, rsp_mem_addr, rsp_mem_read, rsp_mem_write,
                  rsp_mem_wdata, rsp_vram_addr, rsp_temp_addr, rsp_fine_scroll_x,
                  rsp_ctrl_bits, rsp_mask_bits};
         if (port_results_due.size() == 0) begin
            errors++;
            $display("%0t: unexpected response, expected none actual %h", $time, seen);
         end else begin
            due = port_results_due.pop_front();
            check_field("rdata", 16'(due.rdata), 16'(seen.rdata));
            check_field("nmi_level", 16'(due.nmi_level), 16'(seen.nmi_level));
            check_field("mem_addr", 16'(due.mem_addr), 16'(seen.mem_addr));
            check_field("mem_read", 16'(due.mem_read), 16'(seen.mem_read));
            check_field("mem_write", 16'(due.mem_write), 16'(seen.mem_write));
            check_field("mem_wdata", 16'(due.mem_wdata), 16'(seen.mem_wdata));
            check_field("vram_addr", 16'(due.vram_addr), 16'(seen.vram_addr));
            check_field("temp_addr", 16'(due.temp_addr), 16'(seen.temp_addr));
            check_field("fine_scroll_x", 16'(due.fine_scroll_x),
                        16'(seen.fine_scroll_x));
            check_field("ctrl_bits", 16'(due.ctrl_bits), 16'(seen.ctrl_bits));
            check_field("mask_bits", 16'(due.mask_bits), 16'(seen.mask_bits));
         end
      end
      if (req_taken) begin
         it = '{req_type, req_reg_index, req_wdata, req_rendering_active, req_ext_rdata};
         apply_bus_event(it, due);
         port_results_due.push_back(due);
         items_accepted++;
      end
      if (reset || req_taken || rsp_taken) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   initial begin
      int directed;
      int n;
      int p;
      // directed: flags and nmi, both toggle phases, palette mirroring,
      // blocked access, sprite attribute masking, odd registers
      queue_item(vucrp_pkg::REQ_READ, vucrp_pkg::REG_STATUS, 8'h00, 1'b0);
      queue_item(vucrp_pkg::REQ_WRITE, vucrp_pkg::REG_CTRL, 8'h80, 1'b0);
      queue_item(vucrp_pkg::REQ_VBLANK, vucrp_pkg::REG_CTRL, 8'h00, 1'b0);
      queue_item(vucrp_pkg::REQ_SPR_ZERO, vucrp_pkg::REG_CTRL, 8'h00, 1'b0);
      queue_item(vucrp_pkg::REQ_OVERFLOW, vucrp_pkg::REG_CTRL, 8'h00, 1'b0);
      queue_item(vucrp_pkg::REQ_READ, vucrp_pkg::REG_STATUS, 8'h00, 1'b0);
      queue_item(vucrp_pkg::REQ_PRERENDER, vucrp_pkg::REG_CTRL, 8'h00, 1'b0);
      queue_item(vucrp_pkg::REQ_WRITE, vucrp_pkg::REG_SCROLL, 8'hff, 1'b0);
      queue_item(vucrp_pkg::REQ_WRITE, vucrp_pkg::REG_SCROLL, 8'hff, 1'b0);
      queue_item(vucrp_pkg::REQ_WRITE, vucrp_pkg::REG_ADDR, 8'hff, 1'b0);
      queue_item(vucrp_pkg::REQ_WRITE, vucrp_pkg::REG_ADDR, 8'h10, 1'b0);
      queue_item(vucrp_pkg::REQ_WRITE, vucrp_pkg::REG_DATA, 8'hff, 1'b0);
      queue_item(vucrp_pkg::REQ_WRITE, vucrp_pkg::REG_ADDR, 8'h3f, 1'b0);
      queue_item(vucrp_pkg::REQ_WRITE, vucrp_pkg::REG_ADDR, 8'h00, 1'b0);
      queue_item(vucrp_pkg::REQ_READ, vucrp_pkg::REG_DATA, 8'h00, 1'b0);
      queue_item(vucrp_pkg::REQ_WRITE, vucrp_pkg::REG_MASK, 8'hff, 1'b0);
      queue_item(vucrp_pkg::REQ_READ, vucrp_pkg::REG_DATA, 8'h00, 1'b1);
      queue_item(vucrp_pkg::REQ_WRITE, vucrp_pkg::REG_DATA, 8'h5a, 1'b1);
      queue_item(vucrp_pkg::REQ_WRITE, vucrp_pkg::REG_OAM_ADDR, 8'h02, 1'b0);
      queue_item(vucrp_pkg::REQ_WRITE, vucrp_pkg::REG_OAM_DATA, 8'hff, 1'b0);
      queue_item(vucrp_pkg::REQ_WRITE, vucrp_pkg::REG_OAM_ADDR, 8'h02, 1'b0);
      queue_item(vucrp_pkg::REQ_READ, vucrp_pkg::REG_OAM_DATA, 8'h00, 1'b0);
      queue_item(vucrp_pkg::REQ_READ, vucrp_pkg::REG_CTRL, 8'h00, 1'b0);
      queue_item(vucrp_pkg::REQ_WRITE, vucrp_pkg::REG_STATUS, 8'hff, 1'b0);
      queue_item(REQ_UNUSED_A, vucrp_pkg::REG_DATA, 8'hff, 1'b1);
      queue_item(REQ_UNUSED_B, vucrp_pkg::REG_DATA, 8'h00, 1'b0);
      directed = bus_items.size();

      while (bus_items.size() < directed + RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0, 1: begin
               if ($urandom_range(0, 1))
                  queue_item(vucrp_pkg::REQ_READ, vucrp_pkg::REG_STATUS, 8'h00, busy_line());
               if ($urandom_range(0, 2) == 0)
                  queue_item(vucrp_pkg::REQ_WRITE, vucrp_pkg::REG_ADDR,
                             8'h3f | (8'($urandom) & 8'hc0), 1'b0);
               else
                  queue_item(vucrp_pkg::REQ_WRITE, vucrp_pkg::REG_ADDR, 8'($urandom),
                             busy_line());
               queue_item(vucrp_pkg::REQ_WRITE, vucrp_pkg::REG_ADDR, 8'($urandom),
                          busy_line());
               n = $urandom_range(1, 6);
               repeat (n)
                  queue_item($urandom_range(0, 1) ? vucrp_pkg::REQ_WRITE : vucrp_pkg::REQ_READ,
                             vucrp_pkg::REG_DATA, 8'($urandom), busy_line());
            end
            2: begin
               queue_item(vucrp_pkg::REQ_WRITE, vucrp_pkg::REG_SCROLL, 8'($urandom),
                          busy_line());
               queue_item(vucrp_pkg::REQ_WRITE, vucrp_pkg::REG_SCROLL, 8'($urandom),
                          busy_line());
            end
            3: begin
               p = $urandom_range(0, 255);
               n = $urandom_range(1, 4);
               queue_item(vucrp_pkg::REQ_WRITE, vucrp_pkg::REG_OAM_ADDR, 8'(p), busy_line());
               repeat (n)
                  queue_item(vucrp_pkg::REQ_WRITE, vucrp_pkg::REG_OAM_DATA, 8'($urandom),
                             busy_line());
               queue_item(vucrp_pkg::REQ_WRITE, vucrp_pkg::REG_OAM_ADDR, 8'(p), busy_line());
               repeat (n) begin
                  queue_item(vucrp_pkg::REQ_READ, vucrp_pkg::REG_OAM_DATA, 8'($urandom),
                             busy_line());
                  queue_item(vucrp_pkg::REQ_WRITE, vucrp_pkg::REG_OAM_ADDR, 8'(++p),
                             busy_line());
               end
            end
            4: queue_item(vucrp_pkg::REQ_WRITE,
                          $urandom_range(0, 1) ? vucrp_pkg::REG_CTRL : vucrp_pkg::REG_MASK,
                          8'($urandom), busy_line());
            5: begin
               queue_item(3'($urandom_range(2, 5)), 3'($urandom), 8'($urandom), busy_line());
               if ($urandom_range(0, 1))
                  queue_item(vucrp_pkg::REQ_READ, vucrp_pkg::REG_STATUS, 8'h00, busy_line());
            end
            6: queue_item(3'($urandom), 3'($urandom), 8'($urandom),
                          1'($urandom_range(0, 1)));
            7: queue_item($urandom_range(0, 1) ? vucrp_pkg::REQ_WRITE : vucrp_pkg::REQ_READ,
                          vucrp_pkg::REG_DATA, 8'($urandom), busy_line());
            8: begin
               queue_item(vucrp_pkg::REQ_WRITE, vucrp_pkg::REG_ADDR, 8'($urandom),
                          busy_line());
               queue_item(vucrp_pkg::REQ_READ, vucrp_pkg::REG_DATA, 8'($urandom),
                          busy_line());
            end
            default: queue_item(vucrp_pkg::REQ_READ, vucrp_pkg::REG_STATUS, 8'($urandom),
                                busy_line());
         endcase
      end
      items_total = bus_items.size();

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      while (items_accepted < items_total || port_results_due.size() != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
      if (errors == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
